@@ sv/qrs_pkg.sv @@
package qrs_pkg;

	localparam int WORD_WIDTH = 32;
	localparam int FRAC_BITS  = 20;
	localparam int THR_WIDTH  = 10;
	localparam int THR_RESET  = 1;

	localparam int MAG_W      = WORD_WIDTH;
	localparam int PROD_W     = 2 * WORD_WIDTH;
	localparam int D_W        = 2 * WORD_WIDTH + 1;
	localparam int SQ_STAGES  = (D_W + 1) / 2;
	localparam int RAD_W      = 2 * SQ_STAGES;
	localparam int ROOT_W     = SQ_STAGES;
	localparam int SQ_REM_W   = ROOT_W + 3;
	localparam int NUM_W      = ROOT_W + 1;
	localparam int DEN_W      = WORD_WIDTH + 1;
	localparam int DIV_STAGES = WORD_WIDTH;
	localparam int DIV_REM_W  = DEN_W + 1;
	localparam int BIG_SHIFT  = WORD_WIDTH - FRAC_BITS;
	localparam int CMP_W      = DEN_W + BIG_SHIFT;

	typedef logic signed [WORD_WIDTH-1:0] word_t;
	typedef logic [MAG_W-1:0]             mag_t;
	typedef logic [THR_WIDTH-1:0]         thr_t;

	localparam mag_t HALF_MAG = {1'b1, {(MAG_W-1){1'b0}}};
	localparam mag_t ONE_MAG  = MAG_W'(1) << FRAC_BITS;
	localparam bit   ONE_OK   = FRAC_BITS < WORD_WIDTH - 1;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_TWO     = 2'd1,
		KIND_DOUBLE  = 2'd2,
		KIND_COMPLEX = 2'd3
	} kind_t;

	typedef struct packed {
		logic  an;
		mag_t  am;
		logic  bn;
		mag_t  bm;
		kind_t kind;
	} sq_side_t;

	typedef struct packed {
		kind_t kind;
		logic  neg1;
		logic  neg2;
	} dv_side_t;

	typedef struct packed {
		kind_t kind;
		word_t first;
		word_t second;
		logic  ovf;
	} res_t;

	function automatic mag_t mag_of(input word_t v);
		return v[WORD_WIDTH-1] ? mag_t'(~v + 1'b1) : mag_t'(v);
	endfunction

	function automatic word_t encode(input logic neg, input mag_t mag);
		return neg ? word_t'(~mag + 1'b1) : word_t'(mag);
	endfunction

endpackage

@@ sv/qrs_coef_if.sv @@
interface qrs_coef_if;
	import qrs_pkg::*;
	logic  valid;
	logic  ready;
	word_t coef_a;
	word_t coef_b;
	word_t coef_c;
	modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
	modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

@@ sv/qrs_root_if.sv @@
interface qrs_root_if;
	import qrs_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] root_kind;
	word_t      first_value;
	word_t      second_value;
	logic       overflow;
	modport source (output valid, output root_kind, output first_value, output second_value,
		output overflow, input ready);
	modport sink (input valid, input root_kind, input first_value, input second_value,
		input overflow, output ready);
endinterface

@@ sv/qrs_sqrt.sv @@
module qrs_sqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [qrs_pkg::RAD_W-1:0]  rad,
	output logic [qrs_pkg::ROOT_W-1:0] root
);
	import qrs_pkg::*;

	logic [SQ_REM_W-1:0] rem_s  [SQ_STAGES];
	logic [ROOT_W-1:0]   root_s [SQ_STAGES];
	logic [RAD_W-1:0]    rad_s  [SQ_STAGES];

	// one result bit per stage: bring down two radicand bits, try (root*4+1)
	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
		logic [SQ_REM_W-1:0] rem_in;
		logic [ROOT_W-1:0]   root_in;
		logic [RAD_W-1:0]    rad_in;
		logic [SQ_REM_W-1:0] rem_sh;
		logic [SQ_REM_W-1:0] trial;
		logic                take;

		if (g == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
			assign rad_in  = rad_s[g-1];
		end

		assign rem_sh = {rem_in[SQ_REM_W-3:0], rad_in[RAD_W-1 -: 2]};
		assign trial  = {1'b0, root_in, 2'b01};
		assign take   = rem_sh >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= take ? rem_sh - trial : rem_sh;
				root_s[g] <= {root_in[ROOT_W-2:0], take};
				rad_s[g]  <= {rad_in[RAD_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[SQ_STAGES-1];

endmodule

@@ sv/qrs_div.sv @@
module qrs_div (
	input  logic                           clk,
	input  logic                           en,
	input  logic [qrs_pkg::NUM_W-1:0]      num,
	input  logic [qrs_pkg::DEN_W-1:0]      den,
	output logic [qrs_pkg::WORD_WIDTH-1:0] quo,
	output logic                           big
);
	import qrs_pkg::*;

	logic [NUM_W+FRAC_BITS-1:0] dvd;
	logic                       big_in;
	logic [DIV_REM_W-1:0]       rem0;

	logic [DIV_REM_W-1:0]  rem_s [DIV_STAGES];
	logic [WORD_WIDTH-1:0] lo_s  [DIV_STAGES];
	logic [WORD_WIDTH-1:0] quo_s [DIV_STAGES];
	logic [DEN_W-1:0]      den_s [DIV_STAGES];
	logic                  big_s [DIV_STAGES];

	// quotient of 2^WORD_WIDTH or more saturates anyway; flag it and keep the low bits only
	assign dvd    = {num, {FRAC_BITS{1'b0}}};
	assign big_in = CMP_W'(num) >= (CMP_W'(den) << BIG_SHIFT);
	assign rem0   = DIV_REM_W'(dvd >> WORD_WIDTH);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [DIV_REM_W-1:0]  rem_in;
		logic [WORD_WIDTH-1:0] lo_in;
		logic [WORD_WIDTH-1:0] quo_in;
		logic [DEN_W-1:0]      den_in;
		logic                  big_i;
		logic [DIV_REM_W-1:0]  r2;
		logic                  take;

		if (g == 0) begin : g_first
			assign rem_in = rem0;
			assign lo_in  = dvd[WORD_WIDTH-1:0];
			assign quo_in = '0;
			assign den_in = den;
			assign big_i  = big_in;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign lo_in  = lo_s[g-1];
			assign quo_in = quo_s[g-1];
			assign den_in = den_s[g-1];
			assign big_i  = big_s[g-1];
		end

		assign r2   = {rem_in[DIV_REM_W-2:0], lo_in[WORD_WIDTH-1]};
		assign take = r2 >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= take ? r2 - {1'b0, den_in} : r2;
				lo_s[g]  <= {lo_in[WORD_WIDTH-2:0], 1'b0};
				quo_s[g] <= {quo_in[WORD_WIDTH-2:0], take};
				den_s[g] <= den_in;
				big_s[g] <= big_i;
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];
	assign big = big_s[DIV_STAGES-1];

endmodule

@@ sv/quadratic_root_solver.sv @@
// Quadratic root solver: roots of a*x^2 + b*x + c = 0 in signed Q12.20.
// Channel coef (sink) carries one request of coefficients coef_a, coef_b,
// coef_c; channel roots (source) returns one result per request: root_kind,
// first_value, second_value and overflow. cfg_wr_en/cfg_wr_data write the
// 10-bit zero threshold; write it only while no request is in flight.
// A request passes from coef to roots through 72 register stages: four
// front stages (split, multiply, discriminant, snap), 33 square-root
// stages (one root bit per stage), one numerator stage, 32 divider stages
// (one quotient bit per stage, two lanes side by side), one saturation
// stage and the output register.
// One request is accepted every cycle while the spare output entry is free.
// The whole pipeline moves on one enable; a two-entry output buffer
// (output register plus spare) absorbs the result still in flight when
// the receiver stalls, so coef.ready drops once a result is parked in
// the spare entry and rises again as soon as the spare entry drains. Nothing
// is lost or repeated across a stall.
// Reset (arst_n low) empties the pipeline and the output buffer and loads
// the threshold with 1.
module quadratic_root_solver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [qrs_pkg::THR_WIDTH-1:0] cfg_wr_data,
	qrs_coef_if.sink                      coef,
	qrs_root_if.source                    roots
);
	import qrs_pkg::*;

	thr_t thr_q;
	logic en;
	logic acc;
	logic out_valid_q, spare_valid_q;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= thr_t'(THR_RESET);
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// pipeline advances whenever the spare output entry is free
	assign en         = ~spare_valid_q;
	assign coef.ready = en;
	assign acc        = coef.valid & en;

	// ---- stage 1: split into sign and magnitude ----
	logic v_s1, an_s1, bn_s1, cn_s1;
	mag_t am_s1, bm_s1, cm_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			an_s1 <= coef.coef_a[WORD_WIDTH-1];
			bn_s1 <= coef.coef_b[WORD_WIDTH-1];
			cn_s1 <= coef.coef_c[WORD_WIDTH-1];
			am_s1 <= mag_of(coef.coef_a);
			bm_s1 <= mag_of(coef.coef_b);
			cm_s1 <= mag_of(coef.coef_c);
		end
	end

	// ---- stage 2: b*b and a*c on magnitudes ----
	logic              v_s2, an_s2, bn_s2, cn_s2;
	mag_t              am_s2, bm_s2;
	logic [PROD_W-1:0] b2_s2, ac_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			an_s2 <= an_s1;
			bn_s2 <= bn_s1;
			cn_s2 <= cn_s1;
			am_s2 <= am_s1;
			bm_s2 <= bm_s1;
			b2_s2 <= bm_s1 * bm_s1;
			ac_s2 <= am_s1 * cm_s1;
		end
	end

	// ---- stage 3: discriminant as sign and magnitude ----
	logic              v_s3, an_s3, bn_s3, dneg_s3;
	mag_t              am_s3, bm_s3;
	logic [D_W-1:0]    dmag_s3;
	logic [PROD_W+1:0] m4, b2x, dsum;
	logic              dneg;

	always_comb begin
		m4  = {ac_s2, 2'b00};
		b2x = (PROD_W+2)'(b2_s2);
		// opposite signs of a and c: -4ac adds to b^2
		if (an_s2 != cn_s2) begin
			dsum = b2x + m4;
			dneg = 1'b0;
		end else if (m4 <= b2x) begin
			dsum = b2x - m4;
			dneg = 1'b0;
		end else begin
			dsum = m4 - b2x;
			dneg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_s3   <= an_s2;
			bn_s3   <= bn_s2;
			am_s3   <= am_s2;
			bm_s3   <= bm_s2;
			dmag_s3 <= D_W'(dsum);
			dneg_s3 <= dneg;
		end
	end

	// ---- stage 4: snap a, b, D and classify ----
	logic           v_s4;
	sq_side_t       side_s4;
	logic [RAD_W-1:0] rad_s4;
	logic           dzero, bsmall, asmall;
	kind_t          kind4;

	always_comb begin
		dzero  = dmag_s3 <= (D_W'(thr_q) << FRAC_BITS);
		bsmall = bm_s3 <= MAG_W'(thr_q);
		asmall = am_s3 <= MAG_W'(thr_q);
		if (asmall) begin
			kind4 = KIND_NONE;
		end else if (dzero) begin
			kind4 = KIND_DOUBLE;
		end else if (!dneg_s3) begin
			kind4 = KIND_TWO;
		end else begin
			kind4 = KIND_COMPLEX;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.an   <= an_s3;
			side_s4.am   <= am_s3;
			side_s4.bn   <= bsmall ? 1'b0 : bn_s3;
			side_s4.bm   <= bsmall ? '0 : bm_s3;
			side_s4.kind <= kind4;
			rad_s4       <= dzero ? '0 : RAD_W'(dmag_s3);
		end
	end

	// ---- square root of |D|, with side data alongside ----
	logic [ROOT_W-1:0] sq_root;
	sq_side_t          side_sq_s [SQ_STAGES];
	logic              vld_sq_s  [SQ_STAGES];

	qrs_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s4),
		.root (sq_root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_sq_s[0] <= side_s4;
			for (int i = 1; i < SQ_STAGES; i++) begin
				side_sq_s[i] <= side_sq_s[i-1];
			end
		end
	end

	// ---- stage 5: numerators, signs and divisor ----
	sq_side_t         sd;
	logic [NUM_W-1:0] bmx, sx, n1, n2;
	logic             nb, sg1, sg2;
	logic             v_s5;
	logic [NUM_W-1:0] n1_s5, n2_s5;
	logic [DEN_W-1:0] den_s5;
	dv_side_t         side_s5;

	always_comb begin
		sd  = side_sq_s[SQ_STAGES-1];
		bmx = NUM_W'(sd.bm);
		sx  = NUM_W'(sq_root);
		nb  = ~sd.bn;
		n1  = bmx;
		sg1 = nb;
		n2  = sx;
		sg2 = 1'b0;
		if (sd.kind == KIND_TWO) begin
			// -b + sqrt(D)
			if (!nb) begin
				n1  = bmx + sx;
				sg1 = 1'b0;
			end else if (bmx >= sx) begin
				n1  = bmx - sx;
				sg1 = 1'b1;
			end else begin
				n1  = sx - bmx;
				sg1 = 1'b0;
			end
			// -b - sqrt(D)
			if (nb) begin
				n2  = bmx + sx;
				sg2 = 1'b1;
			end else if (bmx >= sx) begin
				n2  = bmx - sx;
				sg2 = 1'b0;
			end else begin
				n2  = sx - bmx;
				sg2 = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s5        <= n1;
			n2_s5        <= n2;
			den_s5       <= {sd.am, 1'b0};
			side_s5.kind <= sd.kind;
			side_s5.neg1 <= sg1 ^ sd.an;
			side_s5.neg2 <= (sd.kind == KIND_COMPLEX) ? 1'b0 : (sg2 ^ sd.an);
		end
	end

	// ---- two divider lanes ----
	logic [WORD_WIDTH-1:0] quo1, quo2;
	logic                  big1, big2;
	dv_side_t              side_dv_s [DIV_STAGES];
	logic                  vld_dv_s  [DIV_STAGES];

	qrs_div u_div1 (
		.clk (clk),
		.en  (en),
		.num (n1_s5),
		.den (den_s5),
		.quo (quo1),
		.big (big1)
	);

	qrs_div u_div2 (
		.clk (clk),
		.en  (en),
		.num (n2_s5),
		.den (den_s5),
		.quo (quo2),
		.big (big2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_dv_s[0] <= side_s5;
			for (int i = 1; i < DIV_STAGES; i++) begin
				side_dv_s[i] <= side_dv_s[i-1];
			end
		end
	end

	// ---- stage 6: saturate, then snap small magnitudes ----
	dv_side_t dd;
	mag_t     lim1, lim2, sat1, sat2;
	logic     o1, o2;
	logic     v_s6, ovf1_s6, ovf2_s6;
	mag_t     mag1_s6, mag2_s6;
	dv_side_t side_s6;

	always_comb begin
		dd   = side_dv_s[DIV_STAGES-1];
		lim1 = dd.neg1 ? HALF_MAG : HALF_MAG - 1'b1;
		lim2 = dd.neg2 ? HALF_MAG : HALF_MAG - 1'b1;
		o1   = big1 | (mag_t'(quo1) > lim1);
		o2   = big2 | (mag_t'(quo2) > lim2);
		sat1 = o1 ? lim1 : mag_t'(quo1);
		sat2 = o2 ? lim2 : mag_t'(quo2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= dd;
			ovf1_s6 <= o1;
			ovf2_s6 <= o2;
			mag1_s6 <= (sat1 <= MAG_W'(thr_q)) ? '0 : sat1;
			mag2_s6 <= (sat2 <= MAG_W'(thr_q)) ? '0 : sat2;
		end
	end

	// ---- result assembly: imaginary part near one, encode, pick fields ----
	mag_t diff, im;
	res_t res;

	always_comb begin
		diff = (mag2_s6 >= ONE_MAG) ? mag2_s6 - ONE_MAG : ONE_MAG - mag2_s6;
		im   = (ONE_OK && diff <= MAG_W'(thr_q)) ? ONE_MAG : mag2_s6;
		res.kind = side_s6.kind;
		unique case (side_s6.kind)
			KIND_NONE: begin
				res.first  = '0;
				res.second = '0;
				res.ovf    = 1'b0;
			end
			KIND_DOUBLE: begin
				res.first  = encode(side_s6.neg1, mag1_s6);
				res.second = '0;
				res.ovf    = ovf1_s6;
			end
			KIND_TWO: begin
				res.first  = encode(side_s6.neg1, mag1_s6);
				res.second = encode(side_s6.neg2, mag2_s6);
				res.ovf    = ovf1_s6 | ovf2_s6;
			end
			KIND_COMPLEX: begin
				res.first  = encode(side_s6.neg1, mag1_s6);
				res.second = encode(1'b0, im);
				res.ovf    = ovf1_s6 | ovf2_s6;
			end
		endcase
	end

	// ---- valid bits travel with the data ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int i = 0; i < SQ_STAGES; i++) begin
				vld_sq_s[i] <= 1'b0;
			end
			for (int i = 0; i < DIV_STAGES; i++) begin
				vld_dv_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1        <= acc;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			vld_sq_s[0] <= v_s4;
			for (int i = 1; i < SQ_STAGES; i++) begin
				vld_sq_s[i] <= vld_sq_s[i-1];
			end
			v_s5        <= vld_sq_s[SQ_STAGES-1];
			vld_dv_s[0] <= v_s5;
			for (int i = 1; i < DIV_STAGES; i++) begin
				vld_dv_s[i] <= vld_dv_s[i-1];
			end
			v_s6        <= vld_dv_s[DIV_STAGES-1];
		end
	end

	// ---- output register with spare entry ----
	res_t out_q, spare_q;
	logic push, pop;

	assign push = en & v_s6;
	assign pop  = out_valid_q & roots.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			// output free this cycle: drain the spare first
			out_valid_q   <= spare_valid_q | push;
			spare_valid_q <= 1'b0;
		end else if (push) begin
			// output held: park the arriving result
			spare_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= spare_valid_q ? spare_q : res;
		end else if (push) begin
			spare_q <= res;
		end
	end

	assign roots.valid        = out_valid_q;
	assign roots.root_kind    = out_q.kind;
	assign roots.first_value  = out_q.first;
	assign roots.second_value = out_q.second;
	assign roots.overflow     = out_q.ovf;

	// ---- checks ----
	a_spare_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> out_valid_q)
		else $error("spare entry holds a result while the output register is empty");

	a_spare_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(spare_valid_q) |-> $past(out_valid_q && !roots.ready))
		else $error("spare entry filled without a stalled output");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_NONE |->
		out_q.first == '0 && out_q.second == '0 && !out_q.ovf)
		else $error("not-quadratic result carries values");

	a_double_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_DOUBLE |-> out_q.second == '0)
		else $error("double root result carries a second value");

	a_imag_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_COMPLEX |-> !out_q.second[WORD_WIDTH-1])
		else $error("imaginary magnitude is negative");

endmodule

@@ dv/tb_quadratic_root_solver.sv @@
`timescale 1ns / 1ps

module tb_quadratic_root_solver;
	import qrs_pkg::*;

	// Expected roots of one coefficient request
	typedef struct {
		kind_t kind;
		word_t first;
		word_t second;
		logic  ovf;
	} roots_t;

	// Scoreboard: predicts the roots of each accepted request and checks results in order
	class root_scoreboard;
		roots_t pending[$];
		int unsigned mismatches;
		int unsigned thr;

		function new();
			mismatches = 0;
			thr = THR_RESET;
		endfunction

		function automatic logic [127:0] quot(input logic [127:0] num, input logic [127:0] den);
			return (num << FRAC_BITS) / den;
		endfunction

		function automatic logic [63:0] sat(input logic neg, input logic [127:0] q,
			inout logic ovf);
			logic [63:0] lim;
			lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
			if (q > lim) begin
				ovf = 1'b1;
				return lim;
			end
			return q[63:0];
		endfunction

		function automatic word_t root_of(input logic nneg, input logic [127:0] nmag,
			input logic aneg, input logic [127:0] den, inout logic ovf);
			logic neg;
			logic [63:0] m;
			neg = nneg != aneg;
			m = sat(neg, quot(nmag, den), ovf);
			if (m <= thr)
				m = 0;
			return neg ? word_t'(-m) : word_t'(m);
		endfunction

		function automatic logic [127:0] isqrt(input logic [127:0] v);
			logic [127:0] r, c;
			r = 0;
			for (int k = 63; k >= 0; k--) begin
				c = r | (128'd1 << k);
				if (c * c <= v)
					r = c;
			end
			return r;
		endfunction

		// Note one accepted request and queue its expected roots
		function void note_request(word_t a, word_t b, word_t c);
			logic an, bn, cn, dneg, ovf, sn;
			logic [127:0] am, bm, cm, b2, m4, dmag, s, den, m, im, one, diff;
			roots_t r;
			an = a[31]; bn = b[31]; cn = c[31];
			am = a[31] ? 128'(-64'(a)) & 128'hffff_ffff : 128'(a) & 128'hffff_ffff;
			bm = b[31] ? 128'(-64'(b)) & 128'hffff_ffff : 128'(b) & 128'hffff_ffff;
			cm = c[31] ? 128'(-64'(c)) & 128'hffff_ffff : 128'(c) & 128'hffff_ffff;
			b2 = bm * bm;
			m4 = (am * cm) << 2;
			if (an != cn) begin
				dmag = b2 + m4; dneg = 0;
			end else if (m4 <= b2) begin
				dmag = b2 - m4; dneg = 0;
			end else begin
				dmag = m4 - b2; dneg = 1;
			end
			// snap small discriminant, threshold lifted into Q24.40
			if (dmag <= (128'(thr) << FRAC_BITS)) begin
				dmag = 0; dneg = 0;
			end
			if (bm <= thr) begin
				bm = 0; bn = 0;
			end
			ovf = 0;
			r.first = 0;
			r.second = 0;
			if (am <= thr) begin
				r.kind = KIND_NONE;
			end else begin
				den = am << 1;
				s = isqrt(dmag);
				if (dmag == 0) begin
					r.kind = KIND_DOUBLE;
					r.first = root_of(!bn, bm, an, den, ovf);
				end else if (!dneg) begin
					r.kind = KIND_TWO;
					// -b + sqrt(D)
					if (bn) begin
						m = bm + s; sn = 0;
					end else if (bm >= s) begin
						m = bm - s; sn = 1;
					end else begin
						m = s - bm; sn = 0;
					end
					r.first = root_of(sn, m, an, den, ovf);
					// -b - sqrt(D)
					if (!bn) begin
						m = bm + s; sn = 1;
					end else if (bm >= s) begin
						m = bm - s; sn = 0;
					end else begin
						m = s - bm; sn = 1;
					end
					r.second = root_of(sn, m, an, den, ovf);
				end else begin
					r.kind = KIND_COMPLEX;
					r.first = root_of(!bn, bm, an, den, ovf);
					im = 128'(sat(1'b0, quot(s, den), ovf));
					if (im <= thr)
						im = 0;
					one = 128'd1 << FRAC_BITS;
					diff = im >= one ? im - one : one - im;
					// snap an imaginary part close to one onto exactly one
					if (ONE_OK && diff <= thr)
						im = one;
					r.second = word_t'(im[31:0]);
				end
			end
			r.ovf = ovf;
			pending.push_back(r);
		endfunction

		// Compare one returned result with the oldest expectation
		function void check_result(logic [1:0] kind, word_t f, word_t s, logic o);
			roots_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind=%0d first=%h second=%h ovf=%b",
						kind, f, s, o);
				return;
			end
			e = pending.pop_front();
			if (kind !== e.kind || f !== e.first || s !== e.second || o !== e.ovf) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch exp kind=%0d first=%h second=%h ovf=%b",
						" / got kind=%0d first=%h second=%h ovf=%b"},
						e.kind, e.first, e.second, e.ovf, kind, f, s, o);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [THR_WIDTH-1:0] cfg_wr_data = '0;

	qrs_coef_if coef();
	qrs_root_if roots();

	quadratic_root_solver uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.coef       (coef.sink),
		.roots      (roots.source)
	);

	root_scoreboard sb = new();
	bit sink_enable = 1'b0;

	initial begin
		coef.valid = 1'b0;
		coef.coef_a = '0;
		coef.coef_b = '0;
		coef.coef_c = '0;
		roots.ready = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Length of a random gap: mostly short, now and then long
	function automatic int gap_len();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0)
			n = 0;
		return n;
	endfunction

	// Offer one request and hold it until the block takes it
	task automatic send_request(word_t a, word_t b, word_t c, bit gaps);
		int n;
		n = gaps ? gap_len() : 0;
		if (n > 0) begin
			coef.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		coef.valid <= 1'b1;
		coef.coef_a <= a;
		coef.coef_b <= b;
		coef.coef_c <= c;
		do
			@(posedge clk);
		while (!coef.ready);
		sb.note_request(a, b, c);
	endtask

	// Wait until every expected result has come, then let the pipe drain
	task automatic drain();
		coef.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_threshold(thr_t v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.thr = v;
	endtask

	function automatic word_t rand_coef();
		case ($urandom_range(0, 5))
			0: return word_t'($urandom);
			1: return word_t'($signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
			2: return word_t'($signed($urandom_range(0, 2047)) - 1024);
			3: return word_t'($signed($urandom_range(0, 64 << FRAC_BITS)) - (32 << FRAC_BITS));
			default: return word_t'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
		endcase
	endfunction

	// Random request: favour double roots and unit imaginary parts now and then
	task automatic send_random(bit gaps);
		word_t a, b, c;
		int sel;
		a = rand_coef();
		b = rand_coef();
		c = rand_coef();
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			// b^2 = 4ac with a = 1: c = b^2/4
			a = 1 << FRAC_BITS;
			b = word_t'($signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
			c = word_t'((longint'(b) * longint'(b)) >>> (FRAC_BITS + 2));
		end else if (sel == 1) begin
			// x^2 + 1 style: imaginary part near one
			a = word_t'($urandom_range(1, 8) << FRAC_BITS);
			b = 0;
			c = word_t'(a + $signed($urandom_range(0, 200)) - 100);
		end
		send_request(a, b, c, gaps);
	endtask

	// Receiver: stall at random, check every accepted result
	always @(posedge clk) begin
		if (roots.valid && roots.ready)
			sb.check_result(roots.root_kind, roots.first_value, roots.second_value,
				roots.overflow);
		if (!sink_enable)
			roots.ready <= 1'b0;
		else if ($urandom_range(0, 19) == 0)
			roots.ready <= 1'b0;
		else if ($urandom_range(0, 99) == 0)
			roots.ready <= 1'b0;
		else
			roots.ready <= ($urandom_range(0, 4) != 0);
	end

	thr_t thr_set[4] = '{10'd0, 10'd1023, 10'd37, 10'd1};

	initial begin
		word_t mx, mn, one;
		mx = word_t'(32'h7fff_ffff);
		mn = word_t'(32'h8000_0000);
		one = word_t'(1 << FRAC_BITS);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sink_enable <= 1'b1;

		// Directed: reset threshold, extremes and each root kind
		send_request(0, one, one, 0);               // a zero: not quadratic
		send_request(one, -3 * one, 2 * one, 0);    // two real roots
		send_request(one, 2 * one, one, 0);         // double root
		send_request(one, 0, one, 0);               // complex, imaginary exactly one
		send_request(one, 2 * one, 5 * one, 0);     // complex pair
		send_request(mx, mx, mx, 0);
		send_request(mn, mn, mn, 0);
		send_request(mx, mn, mx, 0);
		send_request(mn, mx, mn, 0);
		send_request(2, 1, 0, 0);                   // a just above the threshold
		send_request(1, mx, mx, 0);                 // a at the threshold
		send_request(3, mx, mn, 0);                 // saturated roots
		send_request(3, 0, mx, 0);                  // saturated imaginary part
		send_request(-1, mx, 0, 0);
		send_request(word_t'(32'h5555_5555), word_t'(32'haaaa_aaaa), word_t'(32'h5555_5555), 0);
		send_request(word_t'(32'haaaa_aaaa), word_t'(32'h5555_5555), word_t'(32'haaaa_aaaa), 0);
		send_request(one, 1, -one, 0);              // b snapped to zero
		drain();

		// Random phases across threshold settings, extremes included
		for (int p = 0; p < 4; p++) begin
			write_threshold(thr_set[p]);
			for (int i = 0; i < 210; i++) begin
				send_random(!(i >= 80 && i < 120));
				// pause once per phase until every result is back
				if (i == 150) begin
					coef.valid <= 1'b0;
					while (sb.pending.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
sv/qrs_pkg.sv
sv/qrs_coef_if.sv
sv/qrs_root_if.sv
sv/qrs_sqrt.sv
sv/qrs_div.sv
sv/quadratic_root_solver.sv
dv/tb_quadratic_root_solver.sv
